>>> rtl/core/dts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_pkg
// Shared types and constants for the topological scheduler.
// ----------------------------------------------------------------------------
package dts_pkg;

  // Result time field width and its saturation value
  localparam int unsigned TIME_W   = 22;
  localparam logic [TIME_W-1:0] TIME_MAX = '1;

  // Visit marks
  localparam logic [1:0] MARK_FREE = 2'd0;
  localparam logic [1:0] MARK_OPEN = 2'd1;
  localparam logic [1:0] MARK_DONE = 2'd2;

  // Configuration register indexes
  localparam logic [0:0] REG_NODE_COUNT = 1'b0;

  typedef enum logic [1:0] {
    CMD_ADD_EDGE   = 2'd0,
    CMD_SET_WEIGHT = 2'd1,
    CMD_RUN        = 2'd2,
    CMD_CLEAR      = 2'd3
  } cmd_e;

  typedef enum logic [4:0] {
    S_IDLE, S_ADD_RD, S_ADD_WR, S_ADD_LINK, S_CLR, S_START_RD, S_START_CHK,
    S_PUSH_RD, S_PUSH_WR, S_TOP_RD, S_TOP_V, S_SCAN, S_EDGE, S_MARK,
    S_EMIT_RD, S_EMIT_W, S_EMIT_OUT
  } state_e;

  // Controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_in;
    logic wgt_wr;
    logic clear_graph;
    logic add_wr;
    logic add_link;
    logic err_ovf;
    logic err_cycle;
    logic run_init;
    logic clr_step;
    logic start_next;
    logic p_from_start;
    logic p_from_to;
    logic push_wr;
    logic v_load;
    logic finish;
    logic edge_step;
    logic mark_rd_to;
    logic emit_init;
    logic node_load;
    logic emit_load;
  } ctrl_t;

  // Datapath to controller
  typedef struct packed {
    logic add_ok;
    logic edges_full;
    logic run_empty;
    logic had_head;
    logic clr_last;
    logic start_done;
    logic start_seen;
    logic depth_zero;
    logic depth_full;
    logic scan_ok;
    logic target_out;
    logic mark_open;
    logic mark_free;
    logic emit_done;
    logic out_busy;
  } stat_t;

endpackage

>>> rtl/core/dts_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_in_if / dts_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface dts_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] command;
  logic [5:0] source_node;
  logic [5:0] target_node;
  logic [15:0] node_weight;

  modport source (output valid, command, source_node, target_node, node_weight,
                  input ready);
  modport sink (input valid, command, source_node, target_node, node_weight,
                output ready);
endinterface

interface dts_out_if;
  logic        valid;
  logic        ready;
  logic [5:0]  node_index;
  logic [21:0] start_time;
  logic        last;
  logic        cycle_error;
  logic        overflow_error;

  modport source (output valid, node_index, start_time, last, cycle_error,
                  overflow_error, input ready);
  modport sink (input valid, node_index, start_time, last, cycle_error,
                overflow_error, output ready);
endinterface

>>> rtl/core/dts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ram
// Generic simple dual-port RAM, one write port, registered read port.
// ----------------------------------------------------------------------------
module dts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/dts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_ctrl
// Sequencer for loading, the depth-first walk and result emission.
// ----------------------------------------------------------------------------
module dts_ctrl import dts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  input  cmd_e  in_command_i,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;
  logic   take;

  assign take = (state_q == S_IDLE) && !stat_i.out_busy && in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (take) begin
          unique case (in_command_i)
            CMD_ADD_EDGE: begin
              if (stat_i.add_ok && !stat_i.edges_full) state_d = S_ADD_RD;
            end
            CMD_RUN: begin
              if (!stat_i.run_empty) state_d = S_CLR;
            end
            CMD_SET_WEIGHT, CMD_CLEAR: state_d = S_IDLE;
          endcase
        end
      end
      S_ADD_RD:    state_d = S_ADD_WR;
      S_ADD_WR:    state_d = stat_i.had_head ? S_ADD_LINK : S_IDLE;
      S_ADD_LINK:  state_d = S_IDLE;
      S_CLR:       if (stat_i.clr_last) state_d = S_START_RD;
      S_START_RD:  state_d = stat_i.start_done ? S_EMIT_RD : S_START_CHK;
      S_START_CHK: state_d = stat_i.start_seen ? S_START_RD : S_PUSH_RD;
      S_PUSH_RD:   state_d = S_PUSH_WR;
      S_PUSH_WR:   state_d = S_TOP_RD;
      S_TOP_RD:    state_d = stat_i.depth_zero ? S_START_RD : S_TOP_V;
      S_TOP_V:     state_d = S_SCAN;
      S_SCAN:      state_d = stat_i.scan_ok ? S_EDGE : S_TOP_RD;
      S_EDGE:      state_d = stat_i.target_out ? S_TOP_RD : S_MARK;
      S_MARK: begin
        priority if (stat_i.mark_open) state_d = S_IDLE;
        else if (stat_i.mark_free && !stat_i.depth_full) state_d = S_PUSH_RD;
        else state_d = S_TOP_RD;
      end
      S_EMIT_RD:   state_d = stat_i.emit_done ? S_IDLE : S_EMIT_W;
      S_EMIT_W:    state_d = S_EMIT_OUT;
      S_EMIT_OUT:  if (!stat_i.out_busy) state_d = S_EMIT_RD;
      default:     state_d = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    ctrl_o = '0;
    unique case (state_q)
      S_IDLE: begin
        ctrl_o.in_ready = !stat_i.out_busy;
        if (take) begin
          ctrl_o.load_in = 1'b1;
          unique case (in_command_i)
            CMD_ADD_EDGE:   ctrl_o.err_ovf = stat_i.add_ok && stat_i.edges_full;
            CMD_SET_WEIGHT: ctrl_o.wgt_wr = 1'b1;
            CMD_RUN:        ctrl_o.run_init = !stat_i.run_empty;
            CMD_CLEAR:      ctrl_o.clear_graph = 1'b1;
          endcase
        end
      end
      S_ADD_WR:    ctrl_o.add_wr = 1'b1;
      S_ADD_LINK:  ctrl_o.add_link = 1'b1;
      S_CLR:       ctrl_o.clr_step = 1'b1;
      S_START_RD:  ctrl_o.emit_init = stat_i.start_done;
      S_START_CHK: begin
        ctrl_o.start_next   = stat_i.start_seen;
        ctrl_o.p_from_start = !stat_i.start_seen;
      end
      S_PUSH_WR:   ctrl_o.push_wr = 1'b1;
      S_TOP_RD:    ctrl_o.start_next = stat_i.depth_zero;
      S_TOP_V:     ctrl_o.v_load = 1'b1;
      S_SCAN:      ctrl_o.finish = !stat_i.scan_ok;
      S_EDGE: begin
        ctrl_o.edge_step  = 1'b1;
        ctrl_o.mark_rd_to = 1'b1;
      end
      S_MARK: begin
        ctrl_o.err_cycle = stat_i.mark_open;
        ctrl_o.p_from_to = !stat_i.mark_open && stat_i.mark_free && !stat_i.depth_full;
      end
      S_EMIT_W:    ctrl_o.node_load = 1'b1;
      S_EMIT_OUT:  ctrl_o.emit_load = !stat_i.out_busy;
      default:     ctrl_o = '0;
    endcase
  end

endmodule

>>> rtl/core/dts_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dts_datapath
// Edge lists, weights, walk stack, marks, post-order and result register.
// ----------------------------------------------------------------------------
module dts_datapath import dts_pkg::*; #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ctrl_t             ctrl_i,
  output stat_t             stat_o,
  input  logic [1:0]        command_i,
  input  logic [5:0]        source_node_i,
  input  logic [5:0]        target_node_i,
  input  logic [15:0]       node_weight_i,
  input  logic [6:0]        node_count_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [5:0]        node_index_o,
  output logic [TIME_W-1:0] start_time_o,
  output logic              last_o,
  output logic              cycle_error_o,
  output logic              overflow_error_o
);

  localparam int unsigned NIW = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned EIW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);
  localparam int unsigned TW  = WEIGHT_BITS + NCW;
  localparam int unsigned TSW = (TW > TIME_W) ? TW : TIME_W;

  logic [NIW-1:0] src_q, dst_q, p_q, v_q, to_q, node_q, clr_q;
  logic [NCW-1:0] n_q, start_q, depth_q, pc_q, i_q;
  logic [ECW-1:0] total_q;
  logic [EIW-1:0] e_q, t_q;
  logic [MAX_NODES-1:0] head_ok_q, wgt_ok_q;
  logic [TSW-1:0] time_q;
  logic           out_valid_q;

  logic src_ok, dst_ok;
  logic [NCW-1:0] n_in;
  logic [EIW-1:0] head_rd, tail_rd;
  logic [NIW-1:0] target_rd, stack_rd, post_rd;
  logic [EIW:0]   link_rd, scan_rd;
  logic [WEIGHT_BITS-1:0] wgt_rd;
  logic [1:0]     mark_rd;

  logic           mark_we;
  logic [NIW-1:0] mark_waddr, mark_raddr;
  logic [1:0]     mark_wdata;

  assign src_ok = {1'b0, source_node_i} < 7'(MAX_NODES);
  assign dst_ok = {1'b0, target_node_i} < 7'(MAX_NODES);
  assign n_in   = (node_count_i > 7'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(node_count_i);

  // Status
  always_comb begin
    stat_o            = '0;
    stat_o.add_ok     = src_ok && dst_ok;
    stat_o.edges_full = total_q >= ECW'(MAX_EDGES);
    stat_o.run_empty  = node_count_i == 7'd0;
    stat_o.had_head   = head_ok_q[src_q];
    stat_o.clr_last   = clr_q == NIW'(MAX_NODES - 1);
    stat_o.start_done = start_q == n_q;
    stat_o.start_seen = mark_rd != MARK_FREE;
    stat_o.depth_zero = depth_q == '0;
    stat_o.depth_full = depth_q == NCW'(MAX_NODES);
    stat_o.scan_ok    = scan_rd[EIW];
    stat_o.target_out = NCW'(target_rd) >= n_q;
    stat_o.mark_open  = mark_rd == MARK_OPEN;
    stat_o.mark_free  = mark_rd == MARK_FREE;
    stat_o.emit_done  = i_q == '0;
    stat_o.out_busy   = out_valid_q;
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_ok_q   <= '0;
      wgt_ok_q    <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
      depth_q     <= '0;
      pc_q        <= '0;
      i_q         <= '0;
      start_q     <= '0;
      n_q         <= '0;
      clr_q       <= '0;
    end else begin
      if (ctrl_i.clear_graph) begin
        head_ok_q <= '0;
        wgt_ok_q  <= '0;
        total_q   <= '0;
      end
      if (ctrl_i.wgt_wr && src_ok) wgt_ok_q[source_node_i[NIW-1:0]] <= 1'b1;
      if (ctrl_i.add_wr) begin
        head_ok_q[src_q] <= 1'b1;
        total_q          <= total_q + 1'b1;
      end
      if (ctrl_i.run_init) begin
        n_q     <= n_in;
        clr_q   <= '0;
        start_q <= '0;
        depth_q <= '0;
        pc_q    <= '0;
      end
      if (ctrl_i.clr_step) clr_q <= clr_q + 1'b1;
      if (ctrl_i.start_next) start_q <= start_q + 1'b1;
      if (ctrl_i.push_wr) depth_q <= depth_q + 1'b1;
      if (ctrl_i.finish) begin
        depth_q <= depth_q - 1'b1;
        pc_q    <= pc_q + 1'b1;
      end
      if (ctrl_i.emit_init) i_q <= pc_q;
      if (ctrl_i.emit_load) i_q <= i_q - 1'b1;
      if (ctrl_i.emit_load || ctrl_i.err_cycle || ctrl_i.err_ovf) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.load_in) begin
      src_q <= source_node_i[NIW-1:0];
      dst_q <= target_node_i[NIW-1:0];
    end
    if (ctrl_i.add_wr) begin
      e_q <= total_q[EIW-1:0];
      t_q <= tail_rd;
    end
    if (ctrl_i.run_init) time_q <= '0;
    if (ctrl_i.p_from_start) p_q <= start_q[NIW-1:0];
    if (ctrl_i.p_from_to) p_q <= to_q;
    if (ctrl_i.v_load) v_q <= stack_rd;
    if (ctrl_i.edge_step) to_q <= target_rd;
    if (ctrl_i.node_load) node_q <= post_rd;
    if (ctrl_i.emit_load) begin
      node_index_o     <= 6'(node_q);
      start_time_o     <= (time_q > TSW'(TIME_MAX)) ? TIME_MAX : time_q[TIME_W-1:0];
      last_o           <= i_q == NCW'(1);
      cycle_error_o    <= 1'b0;
      overflow_error_o <= 1'b0;
      time_q <= time_q + (wgt_ok_q[node_q] ? TSW'(wgt_rd) : '0);
    end
    if (ctrl_i.err_cycle || ctrl_i.err_ovf) begin
      node_index_o     <= '0;
      start_time_o     <= '0;
      last_o           <= 1'b1;
      cycle_error_o    <= ctrl_i.err_cycle;
      overflow_error_o <= ctrl_i.err_ovf;
    end
  end

  assign out_valid_o = out_valid_q;

  // Per-node list heads and tails
  dts_ram #(.WIDTH(EIW), .DEPTH(MAX_NODES)) u_head (
    .clk_i, .we_i(ctrl_i.add_wr && !head_ok_q[src_q]), .waddr_i(src_q),
    .wdata_i(total_q[EIW-1:0]), .raddr_i(p_q), .rdata_o(head_rd));

  dts_ram #(.WIDTH(EIW), .DEPTH(MAX_NODES)) u_tail (
    .clk_i, .we_i(ctrl_i.add_wr), .waddr_i(src_q),
    .wdata_i(total_q[EIW-1:0]), .raddr_i(src_q), .rdata_o(tail_rd));

  // Edge store: target and link to the next edge of the same source
  dts_ram #(.WIDTH(NIW), .DEPTH(MAX_EDGES)) u_target (
    .clk_i, .we_i(ctrl_i.add_wr), .waddr_i(total_q[EIW-1:0]),
    .wdata_i(dst_q), .raddr_i(scan_rd[EIW-1:0]), .rdata_o(target_rd));

  dts_ram #(.WIDTH(EIW + 1), .DEPTH(MAX_EDGES)) u_link (
    .clk_i, .we_i(ctrl_i.add_wr || ctrl_i.add_link),
    .waddr_i(ctrl_i.add_link ? t_q : total_q[EIW-1:0]),
    .wdata_i(ctrl_i.add_link ? {1'b1, e_q} : '0),
    .raddr_i(scan_rd[EIW-1:0]), .rdata_o(link_rd));

  // Node weights
  dts_ram #(.WIDTH(WEIGHT_BITS), .DEPTH(MAX_NODES)) u_weight (
    .clk_i, .we_i(ctrl_i.wgt_wr && src_ok), .waddr_i(source_node_i[NIW-1:0]),
    .wdata_i(WEIGHT_BITS'(node_weight_i)), .raddr_i(post_rd), .rdata_o(wgt_rd));

  // Visit marks: clearing sweep, push, finish
  always_comb begin
    priority if (ctrl_i.clr_step) begin
      mark_we = 1'b1; mark_waddr = clr_q; mark_wdata = MARK_FREE;
    end else if (ctrl_i.push_wr) begin
      mark_we = 1'b1; mark_waddr = p_q; mark_wdata = MARK_OPEN;
    end else begin
      mark_we = ctrl_i.finish; mark_waddr = v_q; mark_wdata = MARK_DONE;
    end
  end
  assign mark_raddr = ctrl_i.mark_rd_to ? target_rd : start_q[NIW-1:0];

  dts_ram #(.WIDTH(2), .DEPTH(MAX_NODES)) u_mark (
    .clk_i, .we_i(mark_we), .waddr_i(mark_waddr), .wdata_i(mark_wdata),
    .raddr_i(mark_raddr), .rdata_o(mark_rd));

  // Walk stack
  dts_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES)) u_stack (
    .clk_i, .we_i(ctrl_i.push_wr), .waddr_i(depth_q[NIW-1:0]), .wdata_i(p_q),
    .raddr_i(NIW'(depth_q - 1'b1)), .rdata_o(stack_rd));

  // Scan position per node
  dts_ram #(.WIDTH(EIW + 1), .DEPTH(MAX_NODES)) u_scan (
    .clk_i, .we_i(ctrl_i.push_wr || ctrl_i.edge_step),
    .waddr_i(ctrl_i.push_wr ? p_q : v_q),
    .wdata_i(ctrl_i.push_wr ? {head_ok_q[p_q], head_rd} : link_rd),
    .raddr_i(stack_rd), .rdata_o(scan_rd));

  // Post-order list
  dts_ram #(.WIDTH(NIW), .DEPTH(MAX_NODES)) u_post (
    .clk_i, .we_i(ctrl_i.finish && (pc_q < NCW'(MAX_NODES))),
    .waddr_i(pc_q[NIW-1:0]), .wdata_i(v_q),
    .raddr_i(NIW'(i_q - 1'b1)), .rdata_o(post_rd));

  // Unused command bits are consumed by the controller
  logic unused_cmd;
  assign unused_cmd = ^command_i;

  // Stack never exceeds the node count in use
  assert property (@(posedge clk_i) disable iff (!rst_ni) depth_q <= n_q || depth_q == '0)
    else $error("walk stack deeper than node count");
  // Finished nodes never exceed the nodes in use
  assert property (@(posedge clk_i) disable iff (!rst_ni) pc_q <= n_q || ctrl_i.run_init)
    else $error("post-order longer than node count");
  // Emission count never exceeds the post-order length
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl_i.emit_load |-> i_q != '0)
    else $error("result emitted past the post-order");

endmodule

>>> rtl/core/dfs_topological_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dfs_topological_scheduler
// Loads a weighted directed graph and emits a topological order with start
// times, found by an iterative depth-first walk with cycle detection.
// ----------------------------------------------------------------------------
// Weight and clear commands are taken one beat per cycle while no result
// beat waits; an add edge holds the block while the list tail is read, the
// edge written and, if the source had a list, the tail linked, and an add
// edge on a full edge store gives one error beat that holds the input until
// it is taken. A run first sweeps the visit marks, then walks: start nodes
// are checked in turn, each edge of the node on top of the stack is scanned
// and nodes are pushed and finished, each step bounded by the registered
// read of the mark, stack and edge RAMs. Results then leave in turn, each
// after the last is taken; a cycle gives one error beat with last set.
module dfs_topological_scheduler import dts_pkg::*; #(
  parameter int unsigned MAX_NODES   = 64,
  parameter int unsigned MAX_EDGES   = 256,
  parameter int unsigned WEIGHT_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  dts_in_if.sink      in_i,
  dts_out_if.source   out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  ctrl_t      ctrl;
  stat_t      stat;
  logic [6:0] node_count_q;
  logic       reg_hit;

  // Configuration register
  assign pready  = 1'b1;
  assign reg_hit = paddr[2] == REG_NODE_COUNT;
  assign prdata  = reg_hit ? 32'(node_count_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 7'd64;
    end else if (psel && penable && pwrite && reg_hit) begin
      node_count_q <= pwdata[6:0];
    end
  end

  logic unused_addr;
  assign unused_addr = ^{paddr[1:0], pwdata[31:7]};

  dts_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i  (in_i.valid),
    .in_command_i(cmd_e'(in_i.command)),
    .stat_i      (stat),
    .ctrl_o      (ctrl)
  );

  dts_datapath #(
    .MAX_NODES(MAX_NODES), .MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)
  ) u_datapath (
    .clk_i, .rst_ni,
    .ctrl_i          (ctrl),
    .stat_o          (stat),
    .command_i       (in_i.command),
    .source_node_i   (in_i.source_node),
    .target_node_i   (in_i.target_node),
    .node_weight_i   (in_i.node_weight),
    .node_count_i    (node_count_q),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .node_index_o    (out_o.node_index),
    .start_time_o    (out_o.start_time),
    .last_o          (out_o.last),
    .cycle_error_o   (out_o.cycle_error),
    .overflow_error_o(out_o.overflow_error)
  );

  assign in_i.ready = ctrl.in_ready;

  // A new command is never taken while a result beat waits
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_i.ready |-> !out_o.valid)
    else $error("command accepted with result pending");
  // Error beats close the run and carry no node
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid && (out_o.cycle_error || out_o.overflow_error)
      |-> out_o.last && out_o.node_index == '0)
    else $error("malformed error beat");
  // Both error kinds never appear together
  assert property (@(posedge clk_i) disable iff (!rst_ni)
      out_o.valid |-> !(out_o.cycle_error && out_o.overflow_error))
    else $error("both error flags set");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the topological scheduler. It loads weighted
// graphs, runs the sort and compares every result beat with a behavioural
// copy of the depth-first walk or, for two directed runs, a fixed error
// beat. It covers node count settings, cycles and idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import dts_pkg::*;

  localparam int unsigned NODES = 64;
  localparam int unsigned EDGES = 256;
  localparam logic [2:0]  ADDR_NODE_COUNT = {REG_NODE_COUNT, 2'b00};

  typedef struct packed {
    logic [5:0]        node;
    logic [TIME_W-1:0] start;
    logic              last;
    logic              cyc;
    logic              ovf;
  } beat_t;

  typedef struct {
    cmd_e        op;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [15:0] wgt;
    bit          typed;
    beat_t       want;
  } step_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata, prdata;
  logic        pready;

  dts_in_if  cmd_if ();
  dts_out_if res_if ();

  dfs_topological_scheduler dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (cmd_if),
    .out_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the graph and configuration
  logic [8:0]  list_head [NODES];
  logic [8:0]  list_tail [NODES];
  bit          head_used [NODES];
  logic [5:0]  edge_dst  [EDGES];
  logic [8:0]  edge_next [EDGES];
  bit          next_used [EDGES];
  int unsigned edge_cnt;
  logic [15:0] node_wgt  [NODES];
  logic [6:0]  node_cnt;

  beat_t       pending_beats[$];
  int unsigned errors;
  int unsigned send_idle, recv_idle;
  int unsigned beats_seen, runs_sent, cycle_runs, ovf_beats;
  step_t       rows[$];

  // Clock
  always begin
    clk_i = 1'b1; #10;
    clk_i = 1'b0; #10;
  end

  function automatic void graph_clear();
    for (int i = 0; i < NODES; i++) begin
      head_used[i] = 0; list_head[i] = '0; list_tail[i] = '0; node_wgt[i] = '0;
    end
    for (int i = 0; i < EDGES; i++) begin
      next_used[i] = 0; edge_next[i] = '0; edge_dst[i] = '0;
    end
    edge_cnt = 0;
  endfunction

  // Works out the result beats of one command and updates the shadow state
  function automatic void schedule_cmd(step_t s, ref beat_t q[$]);
    int unsigned n, depth, post_cnt, v, e, to;
    logic [1:0]  mark [NODES];
    logic [5:0]  stack [NODES];
    logic [8:0]  scan_at [NODES];
    bit          scan_live [NODES];
    logic [5:0]  post [NODES];
    longint unsigned acc;
    bit          looped;
    case (s.op)
      CMD_ADD_EDGE: begin
        if (edge_cnt >= EDGES) begin
          q.insert(q.size(), '{node: '0, start: '0, last: 1'b1, cyc: 1'b0, ovf: 1'b1});
          return;
        end
        edge_dst[edge_cnt] = s.dst;
        next_used[edge_cnt] = 0;
        edge_next[edge_cnt] = '0;
        if (head_used[s.src]) begin
          edge_next[list_tail[s.src]] = edge_cnt[8:0];
          next_used[list_tail[s.src]] = 1;
        end else begin
          list_head[s.src] = edge_cnt[8:0];
          head_used[s.src] = 1;
        end
        list_tail[s.src] = edge_cnt[8:0];
        edge_cnt++;
      end
      CMD_SET_WEIGHT: node_wgt[s.src] = s.wgt;
      CMD_CLEAR:      graph_clear();
      default: begin
        n = (node_cnt > NODES) ? NODES : node_cnt;
        if (n == 0) return;
        for (int i = 0; i < NODES; i++) begin
          mark[i] = MARK_FREE; scan_live[i] = 0;
        end
        post_cnt = 0;
        looped = 0;
        for (int st = 0; st < n && !looped; st++) begin
          if (mark[st] != MARK_FREE) continue;
          mark[st] = MARK_OPEN;
          scan_live[st] = head_used[st];
          scan_at[st] = list_head[st];
          stack[0] = st[5:0];
          depth = 1;
          while (depth > 0 && !looped) begin
            v = stack[depth-1];
            if (scan_live[v]) begin
              e = scan_at[v];
              to = edge_dst[e];
              scan_live[v] = next_used[e];
              scan_at[v] = edge_next[e];
              if (to >= n) continue;
              if (mark[to] == MARK_OPEN) looped = 1;
              else if (mark[to] == MARK_FREE && depth < NODES) begin
                mark[to] = MARK_OPEN;
                scan_live[to] = head_used[to];
                scan_at[to] = list_head[to];
                stack[depth] = to[5:0];
                depth++;
              end
            end else begin
              mark[v] = MARK_DONE;
              post[post_cnt] = v[5:0];
              post_cnt++;
              depth--;
            end
          end
        end
        if (looped) begin
          q.insert(q.size(), '{node: '0, start: '0, last: 1'b1, cyc: 1'b1, ovf: 1'b0});
          return;
        end
        acc = 0;
        for (int i = post_cnt; i > 0; i--) begin
          q.insert(q.size(), '{node: post[i-1],
                               start: (acc > TIME_MAX) ? TIME_MAX : acc[TIME_W-1:0],
                               last: (i == 1), cyc: 1'b0, ovf: 1'b0});
          acc += node_wgt[post[i-1]];
        end
      end
    endcase
  endfunction

  // Drives one command beat and records what it should produce
  task automatic send_cmd(step_t s);
    beat_t got[$];
    while ($urandom_range(0, 99) < send_idle) begin
      cmd_if.valid = 1'b0;
      @(negedge clk_i);
    end
    cmd_if.valid       = 1'b1;
    cmd_if.command     = s.op;
    cmd_if.source_node = s.src;
    cmd_if.target_node = s.dst;
    cmd_if.node_weight = s.wgt;
    do @(posedge clk_i); while (!cmd_if.ready);
    schedule_cmd(s, got);
    if (s.op == CMD_RUN) runs_sent++;
    if (s.typed) pending_beats.insert(pending_beats.size(), s.want);
    else foreach (got[i]) pending_beats.insert(pending_beats.size(), got[i]);
    @(negedge clk_i);
  endtask

  task automatic send_op(cmd_e op, int src, int dst, int wgt);
    step_t s;
    s = '{op: op, src: src[5:0], dst: dst[5:0], wgt: wgt[15:0], typed: 0, want: '0};
    send_cmd(s);
  endtask

  // Let every expected beat arrive, then allow the block to settle
  task automatic drain();
    cmd_if.valid = 1'b0;
    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (150) @(negedge clk_i);
  endtask

  task automatic write_node_count(logic [6:0] value);
    psel = 1'b1; pwrite = 1'b1; paddr = ADDR_NODE_COUNT; pwdata = {25'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
    node_cnt = value;
  endtask

  // One graph: clear, a few weights, mostly forward edges, then a run
  task automatic random_graph(int unsigned n, bit hold_run);
    int unsigned ecount, wcount, a, b;
    send_op(CMD_CLEAR, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
    wcount = $urandom_range(1, 3);
    for (int i = 0; i < wcount; i++)
      send_op(CMD_SET_WEIGHT, $urandom_range(0, n - 1), $urandom_range(0, 63), $urandom);
    ecount = $urandom_range(2, 6);
    for (int i = 0; i < ecount; i++) begin
      a = $urandom_range(0, n - 1);
      b = $urandom_range(0, n - 1);
      if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 63);
      else if (a > b && $urandom_range(0, 19) != 0) begin
        a = a ^ b; b = a ^ b; a = a ^ b;
      end
      send_op(CMD_ADD_EDGE, a, b, $urandom);
    end
    if (hold_run) while (pending_beats.size() != 0) @(negedge clk_i);
    send_op(CMD_RUN, $urandom_range(0, 63), $urandom_range(0, 63), $urandom);
  endtask

  // Result checker
  always @(posedge clk_i) begin
    beat_t w;
    if (rst_ni && res_if.valid && res_if.ready) begin
      beats_seen++;
      if (res_if.cycle_error) cycle_runs++;
      if (res_if.overflow_error) ovf_beats++;
      if (pending_beats.size() == 0) begin
        $error("unexpected result beat: node_index %0d", res_if.node_index);
        errors++;
      end else begin
        w = pending_beats.pop_front();
        if (res_if.node_index !== w.node) begin
          $error("node_index: expected %0d, got %0d", w.node, res_if.node_index);
          errors++;
        end
        if (res_if.start_time !== w.start) begin
          $error("start_time: expected %0d, got %0d", w.start, res_if.start_time);
          errors++;
        end
        if (res_if.last !== w.last) begin
          $error("last: expected %0d, got %0d", w.last, res_if.last);
          errors++;
        end
        if (res_if.cycle_error !== w.cyc) begin
          $error("cycle_error: expected %0d, got %0d", w.cyc, res_if.cycle_error);
          errors++;
        end
        if (res_if.overflow_error !== w.ovf) begin
          $error("overflow_error: expected %0d, got %0d", w.ovf, res_if.overflow_error);
          errors++;
        end
      end
    end
  end

  // Receiver back-pressure
  always @(negedge clk_i) begin
    res_if.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Watchdog
  initial begin
    #40ms;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    logic [6:0] counts [7];
    beat_t cyc_beat;
    cyc_beat = '{node: '0, start: '0, last: 1'b1, cyc: 1'b1, ovf: 1'b0};
    counts = '{7'd1, 7'd0, 7'd127, 7'd100, 7'd5, 7'd64, 7'd12};
    errors = 0; beats_seen = 0; runs_sent = 0; cycle_runs = 0; ovf_beats = 0;
    send_idle = 0; recv_idle = 0;
    cmd_if.valid = 1'b0; cmd_if.command = CMD_CLEAR;
    cmd_if.source_node = '0; cmd_if.target_node = '0; cmd_if.node_weight = '0;
    res_if.ready = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    node_cnt = 7'd64;
    graph_clear();
    rst_ni = 1'b0;
    repeat (2) @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed table: empty graph, extremes, self loop, back edge
    rows.insert(rows.size(), '{CMD_RUN,        6'd0,  6'd0,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_SET_WEIGHT, 6'd63, 6'd0,  16'hFFFF, 0, '0});
    rows.insert(rows.size(), '{CMD_SET_WEIGHT, 6'd0,  6'd63, 16'hFFFF, 0, '0});
    rows.insert(rows.size(), '{CMD_SET_WEIGHT, 6'd5,  6'd0,  16'h0001, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd0,  6'd63, 16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd63, 6'd5,  16'hFFFF, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd5,  6'd1,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd0,  6'd5,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_RUN,        6'd63, 6'd63, 16'hFFFF, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd1,  6'd1,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_RUN,        6'd0,  6'd0,  16'h0000, 1, cyc_beat});
    rows.insert(rows.size(), '{CMD_CLEAR,      6'd0,  6'd0,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd2,  6'd3,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd3,  6'd2,  16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_RUN,        6'd0,  6'd0,  16'h0000, 1, cyc_beat});
    rows.insert(rows.size(), '{CMD_CLEAR,      6'd63, 6'd63, 16'hFFFF, 0, '0});
    rows.insert(rows.size(), '{CMD_SET_WEIGHT, 6'd62, 6'd0,  16'h8000, 0, '0});
    rows.insert(rows.size(), '{CMD_ADD_EDGE,   6'd62, 6'd61, 16'h0000, 0, '0});
    rows.insert(rows.size(), '{CMD_RUN,        6'd0,  6'd0,  16'h0000, 0, '0});
    foreach (rows[i]) send_cmd(rows[i]);

    // Random graphs under three idling regimes and several node counts
    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 33 : (phase == 1) ? 50 : 0;
      recv_idle = (phase == 0) ? 50 : (phase == 1) ? 33 : 0;
      for (int c = 0; c < 7; c++) begin
        drain();
        write_node_count(counts[(c + 2 * phase) % 7]);
        random_graph((counts[(c + 2 * phase) % 7] == 0) ? 64 :
                     (counts[(c + 2 * phase) % 7] > 64) ? 8 :
                     counts[(c + 2 * phase) % 7] + 0, c == 3);
        if (c == 4) random_graph($urandom_range(1, 6), 0);
      end
    end

    drain();
    cmd_if.valid = 1'b0;

    while (pending_beats.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    $display("Covered %0d runs, %0d result beats (%0d cycle and %0d overflow errors),",
             runs_sent, beats_seen, cycle_runs, ovf_beats);
    $display("node counts from 0 to 127 and three back-pressure regimes.");
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
